/* hw/rtl/hex16_instruction_step_defines.svh */
// Assertion macros for the hex16 instruction step block.
`ifndef HEX16_INSTRUCTION_STEP_DEFINES_SVH
`define HEX16_INSTRUCTION_STEP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HEX16_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication on the following cycle, checked out of reset.
`define HEX16_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/hex16_pkg.sv */
// Shared types and constants for the hex16 instruction step block.
package hex16_pkg;

	// major opcodes (high nibble of the instruction byte)
	localparam logic [3:0] OP_LDAM = 4'h0;
	localparam logic [3:0] OP_LDBM = 4'h1;
	localparam logic [3:0] OP_STAM = 4'h2;
	localparam logic [3:0] OP_LDAC = 4'h3;
	localparam logic [3:0] OP_LDBC = 4'h4;
	localparam logic [3:0] OP_LDAP = 4'h5;
	localparam logic [3:0] OP_LDAI = 4'h6;
	localparam logic [3:0] OP_LDBI = 4'h7;
	localparam logic [3:0] OP_STAI = 4'h8;
	localparam logic [3:0] OP_BR   = 4'h9;
	localparam logic [3:0] OP_BRZ  = 4'hA;
	localparam logic [3:0] OP_BRN  = 4'hB;
	localparam logic [3:0] OP_BRB  = 4'hC;
	localparam logic [3:0] OP_OPR  = 4'hD;
	localparam logic [3:0] OP_PFIX = 4'hE;

	// operate sub-codes, taken from the full operand
	localparam logic [15:0] OPR_ADD = 16'd0;
	localparam logic [15:0] OPR_SUB = 16'd1;
	localparam logic [15:0] OPR_IN  = 16'd2;
	localparam logic [15:0] OPR_OUT = 16'd3;

	localparam logic [15:0] CONSOLE_LIMIT = 16'd256;
	localparam logic [15:0] NFIX_MASK     = 16'hFF00;

	typedef enum logic [1:0] {
		MK_NONE,
		MK_LDA,
		MK_LDB,
		MK_ST
	} mem_kind_t;

	typedef struct packed {
		logic [15:0] pc;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] opd;
		logic [15:0] ea;
		mem_kind_t   kind;
		logic        out_valid;
		logic [7:0]  out_byte;
		logic        in_taken;
		logic [3:0]  io_dest;
	} exec_res_t;

endpackage

/* hw/rtl/hex16_instruction_step.sv */
// Top level: 16-bit prefix-operand processor, one step per input transfer.
//
// Input stream (s_axis): each transfer either writes one memory word (op = 0)
// or executes one instruction (op = 1). Output stream (m_axis): one transfer
// per input, carrying pc, A, B, operand and the I/O flags after the step.
// A one-entry input buffer takes the next transfer while the current step
// runs; a result register holds a finished result while the next step runs.
// From input buffer to result register, a memory write passes S_AREQ and
// S_DONE; an instruction adds S_FETCH, a store also S_DREQ, a load S_DREQ
// and S_LOAD. Program and data share one single-port word memory, so fetch
// and data access are serialised on that port, and each word address passes
// through a reduction modulo MEM_WORDS, split by a register, before the port.
// Reset clears pc, A, B, operand and all handshake state; memory contents
// are left as they are and must be written before being read.
// When the receiver stalls, the result is held, one further item is finished
// into the wait state and one more is held in the input buffer before the
// block stops taking transfers.
`include "hex16_instruction_step_defines.svh"

module hex16_instruction_step import hex16_pkg::*; #(
	parameter int MEM_WORDS = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[0], load_addr[15:1], load_data[31:16], in_value[47:32]
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pc_after[15:0], a_after[31:16], b_after[47:32], operand_after[63:48],
	// out_valid[64], out_byte[72:65], in_taken[73], io_dest[77:74], zero[79:78]
	output logic [79:0] m_axis_tdata
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam int RW = 33 - AW;
	localparam int PW = 16 + RW;
	localparam int QW = PW - 32;
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << 32) / MEM_WORDS);
	localparam logic [16:0]   MW    = 17'(MEM_WORDS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_AREQ,
		S_FETCH,
		S_DREQ,
		S_LOAD,
		S_DONE
	} state_t;

	state_t      state_q;

	// input buffer
	logic        in_full_q;
	logic        in_op_q;
	logic [14:0] in_addr_q;
	logic [15:0] in_data_q;
	logic [15:0] in_val_q;
	logic        take;

	// architectural registers
	logic [15:0] pc_q, a_q, b_q, opd_q;
	logic        ovalid_q, itaken_q;
	logic [7:0]  obyte_q;
	logic [3:0]  dest_q;

	// step context
	logic        exec_q;
	logic [15:0] wd_q;
	logic [15:0] inv_q;
	mem_kind_t   kind_q;

	// address reduction
	logic [15:0]    red_in;
	logic [PW-1:0]  red_prod;
	logic [15:0]    red_x_s1;
	logic [PW-1:0]  red_p_s1;
	logic [QW-1:0]  red_quo;
	logic [16:0]    red_qm;
	logic [16:0]    red_t;
	logic [16:0]    red_idx;

	// memory
	logic [15:0]    mem [MEM_WORDS];
	logic [AW-1:0]  mem_addr;
	logic           mem_we;
	logic [15:0]    mem_wdata;
	logic [15:0]    rdata_q;

	logic           out_valid_q;
	logic [79:0]    out_data_q;
	logic           out_free;

	exec_res_t      ex;

	assign take          = (state_q == S_IDLE) && in_full_q;
	assign s_axis_tready = !in_full_q || take;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_full_q <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			in_full_q <= 1'b1;
		end else if (take) begin
			in_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_op_q   <= s_axis_tdata[0];
			in_addr_q <= s_axis_tdata[15:1];
			in_data_q <= s_axis_tdata[31:16];
			in_val_q  <= s_axis_tdata[47:32];
		end
	end

	// word address modulo MEM_WORDS: reciprocal estimate, then one correction
	assign red_in   = (state_q == S_FETCH) ? ex.ea :
		(in_op_q ? {1'b0, pc_q[15:1]} : {1'b0, in_addr_q});
	assign red_prod = PW'(red_in) * PW'(RECIP);
	assign red_quo  = red_p_s1[PW-1:32];
	assign red_qm   = 17'(red_quo * MW);
	assign red_t    = {1'b0, red_x_s1} - red_qm;
	assign red_idx  = (red_t >= MW) ? (red_t - MW) : red_t;
	assign mem_addr = red_idx[AW-1:0];

	assign mem_we    = ((state_q == S_AREQ) && !exec_q) ||
		((state_q == S_DREQ) && (kind_q == MK_ST));
	assign mem_wdata = (state_q == S_DREQ) ? a_q : wd_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		rdata_q <= mem[mem_addr];
	end

	hex16_exec u_exec (
		.inst     (pc_q[0] ? rdata_q[15:8] : rdata_q[7:0]),
		.pc       (pc_q),
		.a        (a_q),
		.b        (b_q),
		.opd_in   (opd_q),
		.in_value (inv_q),
		.res      (ex)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			opd_q       <= '0;
			ovalid_q    <= 1'b0;
			itaken_q    <= 1'b0;
			obyte_q     <= '0;
			dest_q      <= '0;
			exec_q      <= 1'b0;
			wd_q        <= '0;
			inv_q       <= '0;
			kind_q      <= MK_NONE;
			red_x_s1    <= '0;
			red_p_s1    <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// set when a finished step is loaded, held while the receiver stalls
			out_valid_q <= ((state_q == S_DONE) && out_free) ||
				(out_valid_q && !m_axis_tready);
			case (state_q)
				S_IDLE: begin
					if (take) begin
						exec_q   <= in_op_q;
						wd_q     <= in_data_q;
						inv_q    <= in_val_q;
						ovalid_q <= 1'b0;
						itaken_q <= 1'b0;
						obyte_q  <= '0;
						dest_q   <= '0;
						red_x_s1 <= red_in;
						red_p_s1 <= red_prod;
						state_q  <= S_AREQ;
					end
				end
				S_AREQ: begin
					state_q <= exec_q ? S_FETCH : S_DONE;
				end
				S_FETCH: begin
					pc_q     <= ex.pc;
					a_q      <= ex.a;
					b_q      <= ex.b;
					opd_q    <= ex.opd;
					ovalid_q <= ex.out_valid;
					obyte_q  <= ex.out_byte;
					itaken_q <= ex.in_taken;
					dest_q   <= ex.io_dest;
					kind_q   <= ex.kind;
					red_x_s1 <= red_in;
					red_p_s1 <= red_prod;
					state_q  <= (ex.kind == MK_NONE) ? S_DONE : S_DREQ;
				end
				S_DREQ: begin
					state_q <= (kind_q == MK_ST) ? S_DONE : S_LOAD;
				end
				S_LOAD: begin
					if (kind_q == MK_LDA)
						a_q <= rdata_q;
					else
						b_q <= rdata_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_data_q  <= {2'b00, dest_q, itaken_q, obyte_q, ovalid_q,
							opd_q, b_q, a_q, pc_q};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HEX16_ASSERT_NOW(a_mem_we_phase, mem_we, (state_q == S_AREQ) || (state_q == S_DREQ), "memory write outside an access cycle")
	`HEX16_ASSERT_NEXT(a_fetch_after_req, (state_q == S_AREQ) && exec_q, state_q == S_FETCH, "fetch did not follow its read request")
	`HEX16_ASSERT_NOW(a_load_after_dreq, state_q == S_LOAD, $past(state_q == S_DREQ) && (kind_q == MK_LDA || kind_q == MK_LDB), "load completion without a load request")

endmodule

/* hw/rtl/hex16_exec.sv */
// Instruction decode and register update for one fetched instruction byte.
module hex16_exec import hex16_pkg::*; (
	input  logic [7:0]  inst,
	input  logic [15:0] pc,
	input  logic [15:0] a,
	input  logic [15:0] b,
	input  logic [15:0] opd_in,
	input  logic [15:0] in_value,
	output exec_res_t   res
);

	logic [15:0] opd;
	logic [15:0] pc1;
	logic [15:0] pc_rel;
	logic [15:0] opd_sh;
	logic [3:0]  chan;

	assign opd    = opd_in | {12'd0, inst[3:0]};
	assign pc1    = pc + 16'd1;
	assign pc_rel = pc1 + opd;
	assign opd_sh = {opd[11:0], 4'd0};
	assign chan   = (b < CONSOLE_LIMIT) ? 4'd0 : ({1'b0, b[10:8]} + 4'd1);

	always_comb begin
		res           = '0;
		res.pc        = pc1;
		res.a         = a;
		res.b         = b;
		res.opd       = 16'd0;
		res.ea        = opd;
		res.kind      = MK_NONE;
		case (inst[7:4])
			OP_LDAM: res.kind = MK_LDA;
			OP_LDBM: res.kind = MK_LDB;
			OP_STAM: res.kind = MK_ST;
			OP_LDAC: res.a = opd;
			OP_LDBC: res.b = opd;
			OP_LDAP: res.a = pc_rel;
			OP_LDAI: begin
				res.kind = MK_LDA;
				res.ea   = a + opd;
			end
			OP_LDBI: begin
				res.kind = MK_LDB;
				res.ea   = b + opd;
			end
			OP_STAI: begin
				res.kind = MK_ST;
				res.ea   = b + opd;
			end
			OP_BR: res.pc = pc_rel;
			OP_BRZ: begin
				if (a == 16'd0)
					res.pc = pc_rel;
			end
			OP_BRN: begin
				if (a[15])
					res.pc = pc_rel;
			end
			OP_BRB: res.pc = b + opd;
			OP_OPR: begin
				case (opd)
					OPR_ADD: res.a = a + b;
					OPR_SUB: res.a = a - b;
					OPR_IN: begin
						res.a        = in_value;
						res.in_taken = 1'b1;
						res.io_dest  = chan;
					end
					OPR_OUT: begin
						res.out_valid = 1'b1;
						res.out_byte  = a[7:0];
						res.io_dest   = chan;
					end
					default: res.opd = opd;   // undefined: operand kept
				endcase
			end
			OP_PFIX: res.opd = opd_sh;
			default: res.opd = NFIX_MASK | opd_sh;   // negative prefix
		endcase
	end

endmodule
